### sv/vrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vrt_pkg;

  localparam int CHUNK_WIDTH = 16;
  localparam int CHUNK_DEPTH = 16;
  localparam int MAX_VISITS  = 64;
  localparam int CW_LOG2     = $clog2(CHUNK_WIDTH);
  localparam int CD_LOG2     = $clog2(CHUNK_DEPTH);

  localparam int DIV_CYCLES  = 16;
  localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

  localparam logic [4:0]  MAX_DIST_RST = 5'd8;
  localparam logic [10:0] HEIGHT_RST   = 11'd256;

  localparam logic REG_MAX_DIST = 1'b0;
  localparam logic REG_HEIGHT   = 1'b1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RUN
  } back_state_e;

  typedef struct packed {
    logic signed [16:0] voxel;
    logic               neg;
    logic [8:0]         span;
    logic [15:0]        mag;
  } axis_set_t;

  typedef axis_set_t [2:0] ray_set_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage
`default_nettype wire

### sv/vrt_ray_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface vrt_ray_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] origin_x;
  logic signed [23:0] origin_y;
  logic signed [23:0] origin_z;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;

  modport source (output valid, output origin_x, output origin_y, output origin_z,
                  output dir_x, output dir_y, output dir_z, input ready);
  modport sink (input valid, input origin_x, input origin_y, input origin_z,
                input dir_x, input dir_y, input dir_z, output ready);
endinterface
`default_nettype wire

### sv/vrt_voxel_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface vrt_voxel_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] voxel_x;
  logic signed [15:0] voxel_y;
  logic signed [15:0] voxel_z;
  logic signed [11:0] chunk_x;
  logic signed [11:0] chunk_z;
  logic [3:0]         local_x;
  logic [3:0]         local_z;
  logic               in_height;
  logic               last_voxel;

  modport source (output valid, output voxel_x, output voxel_y, output voxel_z,
                  output chunk_x, output chunk_z, output local_x, output local_z,
                  output in_height, output last_voxel, input ready);
  modport sink (input valid, input voxel_x, input voxel_y, input voxel_z,
                input chunk_x, input chunk_z, input local_x, input local_z,
                input in_height, input last_voxel, output ready);
endinterface
`default_nettype wire

### sv/vrt_front.sv
`timescale 1ns / 1ps
`default_nettype none
module vrt_front (
  vrt_ray_if.sink              ray_i,
  input  vrt_pkg::fifo_stat_t  stat_i,
  output logic                 push_o,
  output vrt_pkg::ray_set_t    set_o
);
  import vrt_pkg::*;

  logic signed [23:0] org [3];
  logic signed [15:0] dir [3];
  logic [7:0]         frac [3];

  assign org[0] = ray_i.origin_x;
  assign org[1] = ray_i.origin_y;
  assign org[2] = ray_i.origin_z;
  assign dir[0] = ray_i.dir_x;
  assign dir[1] = ray_i.dir_y;
  assign dir[2] = ray_i.dir_z;

  assign ray_i.ready = !stat_i.full;
  assign push_o      = ray_i.valid && !stat_i.full;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      frac[a]        = org[a][7:0];
      set_o[a].voxel = {org[a][23], org[a][23:8]};
      set_o[a].neg   = dir[a][15] || (dir[a] == 16'sd0);
      set_o[a].span  = set_o[a].neg ? {1'b0, frac[a]} : 9'd256 - {1'b0, frac[a]};
      set_o[a].mag   = dir[a][15] ? 16'(-dir[a]) : 16'(dir[a]);
    end
  end

endmodule
`default_nettype wire

### sv/vrt_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module vrt_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  vrt_pkg::ray_set_t   data_i,
  input  logic                pop_i,
  output vrt_pkg::ray_set_t   data_o,
  output vrt_pkg::fifo_stat_t stat_o
);
  import vrt_pkg::*;

  ray_set_t   mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign data_o       = mem_q[rd_q];
  assign stat_o.full  = cnt_q == 2'd2;
  assign stat_o.empty = cnt_q == 2'd0;

  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

### sv/vrt_div.sv
`timescale 1ns / 1ps
`default_nettype none
module vrt_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [15:0] den_i,
  output logic        busy_o,
  output logic [31:0] quot_o
);
  import vrt_pkg::*;

  logic [31:0]          num_q;
  logic [15:0]          den_q;
  logic [15:0]          rem_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic [16:0]          t1, t2;
  logic                 q1, q2;
  logic [15:0]          r1, r2;

  always_comb begin
    t1 = {rem_q, num_q[31]};
    q1 = t1 >= {1'b0, den_q};
    r1 = q1 ? 16'(t1 - {1'b0, den_q}) : t1[15:0];
    t2 = {r1, num_q[30]};
    q2 = t2 >= {1'b0, den_q};
    r2 = q2 ? 16'(t2 - {1'b0, den_q}) : t2[15:0];
  end

  assign busy_o = busy_q;
  assign quot_o = num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[29:0], q1, q2};
      rem_q <= r2;
    end
  end

endmodule
`default_nettype wire

### sv/vrt_back.sv
`timescale 1ns / 1ps
`default_nettype none
module vrt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vrt_pkg::fifo_stat_t stat_i,
  input  vrt_pkg::ray_set_t   set_i,
  output logic                pop_o,
  input  logic [4:0]          max_dist_i,
  input  logic [10:0]         height_i,
  vrt_voxel_if.source         voxel_o
);
  import vrt_pkg::*;

  back_state_e        state_q, state_d;
  logic signed [16:0] vox_q [3];
  logic               neg_q [3];
  logic [31:0]        tn_q [3];
  logic [31:0]        ts_q [3];
  logic [6:0]         cnt_q;

  logic [31:0] qn [3];
  logic [31:0] qs [3];
  logic [5:0]  busy;
  logic        div_idle;

  logic               out_valid_q;
  logic signed [15:0] vx_q, vy_q, vz_q;
  logic signed [11:0] cx_q, cz_q;
  logic [3:0]         lx_q, lz_q;
  logic               inh_q, last_q;

  logic [1:0]         ax;
  logic [32:0]        tsum;
  logic [31:0]        tnew;
  logic [31:0]        tn_upd [3];
  logic [31:0]        tmin;
  logic               last;
  logic               slot_free;
  logic               emit;
  logic               load_t;
  logic signed [12:0] hl_m1;
  logic               in_h;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    vrt_div u_div_next (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .start_i(pop_o),
      .num_i  ({1'b0, set_i[a].span, 22'd0}),
      .den_i  (set_i[a].mag),
      .busy_o (busy[2*a]),
      .quot_o (qn[a])
    );
    vrt_div u_div_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .start_i(pop_o),
      .num_i  (32'h4000_0000),
      .den_i  (set_i[a].mag),
      .busy_o (busy[2*a+1]),
      .quot_o (qs[a])
    );
  end

  assign div_idle = busy == 6'd0;

  always_comb begin
    if (tn_q[AXIS_X] < tn_q[AXIS_Y]) begin
      ax = (tn_q[AXIS_X] < tn_q[AXIS_Z]) ? AXIS_X : AXIS_Z;
    end else begin
      ax = (tn_q[AXIS_Y] < tn_q[AXIS_Z]) ? AXIS_Y : AXIS_Z;
    end
    tsum = {1'b0, tn_q[ax]} + {1'b0, ts_q[ax]};
    tnew = tsum[32] ? '1 : tsum[31:0];
    for (int a = 0; a < 3; a++) begin
      tn_upd[a] = (2'(a) == ax) ? tnew : tn_q[a];
    end
    tmin = tn_upd[0];
    if (tn_upd[1] < tmin) tmin = tn_upd[1];
    if (tn_upd[2] < tmin) tmin = tn_upd[2];
    last = (tmin >= {11'd0, max_dist_i, 16'd0}) || (cnt_q == 7'(MAX_VISITS - 1));
    hl_m1 = $signed({2'b00, height_i}) - 13'sd1;
    in_h  = !vox_q[1][16] && (vox_q[1] < $signed({{4{hl_m1[12]}}, hl_m1}));
  end

  assign slot_free = !out_valid_q || voxel_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (!stat_i.empty) state_d = ST_DIV;
      ST_DIV: begin
        if (div_idle) state_d = (max_dist_i == 5'd0) ? ST_IDLE : ST_RUN;
      end
      ST_RUN: if (slot_free && last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o  = (state_q == ST_IDLE) && !stat_i.empty;
    load_t = (state_q == ST_DIV) && div_idle;
    emit   = (state_q == ST_RUN) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (voxel_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int a = 0; a < 3; a++) begin
        vox_q[a] <= set_i[a].voxel;
        neg_q[a] <= set_i[a].neg;
      end
    end
    if (load_t) begin
      for (int a = 0; a < 3; a++) begin
        tn_q[a] <= qn[a];
        ts_q[a] <= qs[a];
      end
      cnt_q <= '0;
    end
    if (emit) begin
      vx_q   <= vox_q[0][15:0];
      vy_q   <= vox_q[1][15:0];
      vz_q   <= vox_q[2][15:0];
      cx_q   <= 12'(vox_q[0] >>> CW_LOG2);
      cz_q   <= 12'(vox_q[2] >>> CD_LOG2);
      lx_q   <= 4'(vox_q[0][CW_LOG2-1:0]);
      lz_q   <= 4'(vox_q[2][CD_LOG2-1:0]);
      inh_q  <= in_h;
      last_q <= last;
      for (int a = 0; a < 3; a++) begin
        tn_q[a] <= tn_upd[a];
      end
      vox_q[ax] <= neg_q[ax] ? vox_q[ax] - 17'sd1 : vox_q[ax] + 17'sd1;
      cnt_q     <= cnt_q + 7'd1;
    end
  end

  assign voxel_o.valid      = out_valid_q;
  assign voxel_o.voxel_x    = vx_q;
  assign voxel_o.voxel_y    = vy_q;
  assign voxel_o.voxel_z    = vz_q;
  assign voxel_o.chunk_x    = cx_q;
  assign voxel_o.chunk_z    = cz_q;
  assign voxel_o.local_x    = lx_q;
  assign voxel_o.local_z    = lz_q;
  assign voxel_o.in_height  = inh_q;
  assign voxel_o.last_voxel = last_q;

endmodule
`default_nettype wire

### sv/voxel_ray_traversal_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// steps a ray through the voxel grid, one result item per visited voxel, the last one flagged.
// a ray visits up to 64 voxels: it is picked from the two-entry queue, the radix-4 dividers form
// t_next and t_step for all three axes at once, the results are loaded, then one voxel per cycle
// comes from the stepping datapath when the output register is free. the front keeps taking rays
// while the queue has room.
// registers: max_distance at 0x0, height_limit at 0x4.
module voxel_ray_traversal_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  vrt_ray_if.sink     ray_i,
  vrt_voxel_if.source voxel_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vrt_pkg::*;

  logic [4:0]  max_dist_q;
  logic [10:0] height_q;
  logic        wr_en;
  fifo_stat_t  stat;
  ray_set_t    set_in, set_out;
  logic        push, pop;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_HEIGHT) ? {21'd0, height_q} : {27'd0, max_dist_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= MAX_DIST_RST;
      height_q   <= HEIGHT_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_MAX_DIST: max_dist_q <= pwdata[4:0];
        REG_HEIGHT:   height_q   <= pwdata[10:0];
        default:      ;
      endcase
    end
  end

  vrt_front u_front (
    .ray_i (ray_i),
    .stat_i(stat),
    .push_o(push),
    .set_o (set_in)
  );

  vrt_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .data_i(set_in),
    .pop_i (pop),
    .data_o(set_out),
    .stat_o(stat)
  );

  vrt_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stat_i    (stat),
    .set_i     (set_out),
    .pop_o     (pop),
    .max_dist_i(max_dist_q),
    .height_i  (height_q),
    .voxel_o   (voxel_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && stat.full)) else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && stat.empty)) else $error("pop from empty queue");

  a_pop_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> !stat.full) else $error("queue count off after pop");

  a_height_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (voxel_o.valid && voxel_o.in_height) |-> !voxel_o.voxel_y[15])
    else $error("in_height set for negative y");

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import vrt_pkg::*;

  localparam logic [2:0] ADDR_MAX_DIST = {REG_MAX_DIST, 2'b00};
  localparam logic [2:0] ADDR_HEIGHT   = {REG_HEIGHT, 2'b00};
  localparam int SETTLE_CYCLES = 200;

  typedef struct {
    logic signed [23:0] ox, oy, oz;
    logic signed [15:0] dx, dy, dz;
  } ray_t;

  typedef struct packed {
    logic [15:0] vx, vy, vz;
    logic [11:0] cx, cz;
    logic [3:0]  lx, lz;
    logic        inh, last;
  } voxel_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  vrt_ray_if   ray ();
  vrt_voxel_if vox ();

  voxel_ray_traversal_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ray_i   (ray),
    .voxel_o (vox),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ray_t       pending_rays[$];
  voxel_t     expected_voxels[$];
  logic [4:0]  cfg_max_dist = MAX_DIST_RST;
  logic [10:0] cfg_height   = HEIGHT_RST;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         errors = 0;
  bit         ray_took = 0;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // walk the ray voxel by voxel and queue one expected item per voxel
  function automatic void trace_ray(ray_t r);
    int          org[3];
    int          dir[3];
    int          pos[3];
    logic [31:0] tn[3];
    logic [31:0] ts[3];
    bit          neg[3];
    int unsigned frac, span, mag;
    logic [31:0] limit, tmin;
    logic [32:0] sum;
    int          n, ax;
    voxel_t      v;
    bit          done;
    org = '{int'(r.ox), int'(r.oy), int'(r.oz)};
    dir = '{int'(r.dx), int'(r.dy), int'(r.dz)};
    for (int a = 0; a < 3; a++) begin
      frac   = org[a] & 255;
      pos[a] = org[a] >>> 8;
      neg[a] = !(dir[a] > 0);
      mag    = (dir[a] < 0) ? -dir[a] : dir[a];
      span   = neg[a] ? frac : 256 - frac;
      if (mag == 0) begin
        tn[a] = '1;
        ts[a] = '1;
      end else begin
        tn[a] = 32'((64'(span) << 22) / mag);
        ts[a] = 32'((64'd1 << 30) / mag);
      end
    end
    limit = {11'd0, cfg_max_dist, 16'd0};
    if (limit == 0) return;
    n = 0;
    done = 0;
    while (!done) begin
      v.vx  = pos[0][15:0];
      v.vy  = pos[1][15:0];
      v.vz  = pos[2][15:0];
      v.cx  = 12'(pos[0] >>> CW_LOG2);
      v.cz  = 12'(pos[2] >>> CD_LOG2);
      v.lx  = pos[0][3:0];
      v.lz  = pos[2][3:0];
      v.inh = (pos[1] >= 0) && (pos[1] < int'(cfg_height) - 1);
      n++;
      if (tn[0] < tn[1]) ax = (tn[0] < tn[2]) ? 0 : 2;
      else ax = (tn[1] < tn[2]) ? 1 : 2;
      pos[ax] += neg[ax] ? -1 : 1;
      sum = {1'b0, tn[ax]} + {1'b0, ts[ax]};
      tn[ax] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      tmin = tn[0];
      if (tn[1] < tmin) tmin = tn[1];
      if (tn[2] < tmin) tmin = tn[2];
      done = (tmin >= limit) || (n >= MAX_VISITS);
      v.last = done;
      expected_voxels.push_back(v);
    end
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= 10) $display("%t ERROR %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin : monitor
    ray_t   r;
    voxel_t got, want;
    ray_took = ray.valid && ray.ready;
    if (rst_ni && ray_took) begin
      r.ox = ray.origin_x; r.oy = ray.origin_y; r.oz = ray.origin_z;
      r.dx = ray.dir_x; r.dy = ray.dir_y; r.dz = ray.dir_z;
      trace_ray(r);
    end
    if (rst_ni && vox.valid && vox.ready) begin
      got = {vox.voxel_x, vox.voxel_y, vox.voxel_z, vox.chunk_x, vox.chunk_z,
             vox.local_x, vox.local_z, vox.in_height, vox.last_voxel};
      if (expected_voxels.size() == 0) begin
        note_error($sformatf("unexpected item %p", got));
      end else begin
        want = expected_voxels.pop_front();
        if (got.vx !== want.vx || got.vy !== want.vy || got.vz !== want.vz ||
            got.cx !== want.cx || got.cz !== want.cz || got.lx !== want.lx ||
            got.lz !== want.lz || got.inh !== want.inh || got.last !== want.last)
          note_error($sformatf("expected %p got %p", want, got));
      end
    end
  end

  always @(negedge clk_i) begin : driver
    ray_t r;
    if (rst_ni) begin
      if (!ray.valid || ray_took) begin
        if (pending_rays.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          r = pending_rays.pop_front();
          ray.origin_x = r.ox; ray.origin_y = r.oy; ray.origin_z = r.oz;
          ray.dir_x = r.dx; ray.dir_y = r.dy; ray.dir_z = r.dz;
          ray.valid = 1'b1;
        end else begin
          ray.valid = 1'b0;
        end
      end
      vox.ready = $urandom_range(99, 0) >= recv_idle_pct;
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (addr == ADDR_MAX_DIST) cfg_max_dist = data[4:0];
    else if (addr == ADDR_HEIGHT) cfg_height = data[10:0];
  endtask

  task automatic set_config(int max_dist, int height);
    reg_write(ADDR_MAX_DIST, max_dist);
    reg_write(ADDR_HEIGHT, height);
  endtask

  task automatic add_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    ray_t r;
    r.ox = 24'(ox); r.oy = 24'(oy); r.oz = 24'(oz);
    r.dx = 16'(dx); r.dy = 16'(dy); r.dz = 16'(dz);
    pending_rays.push_back(r);
  endtask

  function automatic int rand_dir();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 15) return 0;
    if (pick < 25) return $urandom_range(1, 0) ? 16384 : -16384;
    if (pick < 35) return int'($urandom_range(16, 0)) - 8;
    return int'($urandom_range(32768, 0)) - 16384;
  endfunction

  function automatic int rand_origin();
    int pick;
    pick = $urandom_range(9, 0);
    // near the ends of the 16-bit voxel range
    if (pick == 0) return 24'sh7FFFFF - int'($urandom_range(4095, 0));
    if (pick == 1) return -8388608 + int'($urandom_range(4095, 0));
    if (pick < 5) return int'($urandom_range(65535, 0)) - 32768;
    return int'({{8{1'b0}}, 24'($urandom)} << 8) >>> 8;
  endfunction

  task automatic add_random_rays(int n);
    repeat (n) add_ray(rand_origin(), rand_origin(), rand_origin(),
                       rand_dir(), rand_dir(), rand_dir());
  endtask

  task automatic drain();
    while (pending_rays.size() > 0 || ray.valid || expected_voxels.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    ray.valid = 1'b0;
    ray.origin_x = '0; ray.origin_y = '0; ray.origin_z = '0;
    ray.dir_x = '0; ray.dir_y = '0; ray.dir_z = '0;
    vox.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 18;
    recv_idle_pct = 85;
    // reset values first
    add_ray(0, 0, 0, 9459, 9459, 9459);
    add_ray(128, 128, 128, 9459, 9459, 9459);
    drain();
    set_config(20, 1024);
    add_ray(0, 0, 0, 16384, 0, 0);
    add_ray(0, 0, 0, -16384, 0, 0);
    add_ray(0, 0, 0, 0, 16384, 0);
    add_ray(0, 0, 0, 0, -16384, 0);
    add_ray(0, 0, 0, 0, 0, 16384);
    add_ray(0, 0, 0, 0, 0, -16384);
    add_ray(77, -77, 500, 0, 0, 0);
    add_ray(8388607, 8388607, 8388607, 9459, 9459, 9459);
    add_ray(-8388608, -8388608, -8388608, -9459, -9459, -9459);
    add_ray(0, 0, 0, 1, -1, 16384);
    add_ray(300, -300, -1, 11585, -11585, 0);
    add_ray(0, -512, 0, 0, 16384, 0);
    add_ray(5, 1020 * 256 + 5, -5, 0, 16384, 100);
    add_ray(256, 256, 256, -16384, -16384, -16384);
    add_ray(-1, -1, -1, 16384, -16384, 16384);
    add_ray(8388352, 0, -8388608, 16384, 0, -16384);
    add_random_rays(40);
    drain();

    // zero distance: no items at all
    set_config(0, 0);
    add_random_rays(4);
    drain();

    send_idle_pct = 85;
    recv_idle_pct = 18;
    set_config(1, 1);
    add_random_rays(25);
    drain();
    set_config(5, 2);
    add_random_rays(30);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(31, 2047);
    add_random_rays(25);
    drain();
    set_config(12, 300);
    add_random_rays(25);
    drain();

    if (errors == 0 && expected_voxels.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

### files.f
sv/vrt_pkg.sv
sv/vrt_ray_if.sv
sv/vrt_voxel_if.sv
sv/vrt_front.sv
sv/vrt_fifo.sv
sv/vrt_div.sv
sv/vrt_back.sv
sv/voxel_ray_traversal_unit.sv
tb/testbench.sv
